@@ hdl/sida_pkg.sv @@
// Shared types and constants of the servo idle-detach axis block.
package sida_pkg;

    localparam int SAMPLE_W = 10;
    localparam int IDLE_W   = 8;
    localparam int US_W     = 15;
    localparam int TICK_W   = 16;

    // Saturation value of the per-axis idle count.
    localparam logic [IDLE_W-1:0] IDLE_SAT = 8'hFF;

    // Full-scale sample; the pulse mapping divides by this.
    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = 10'd1023;

    // The 20000 us period is 625 * 32: shift by 5, then divide by 625
    // through a reciprocal multiply and one correction step.
    localparam int               PERIOD_SHIFT = 5;
    localparam logic [9:0]       PERIOD_ODD   = 10'd625;
    localparam int               RECIP_SHIFT  = 36;
    localparam logic [26:0]      RECIP_625    = 27'd109951162;
    localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

    // Register reset values.
    localparam logic [9:0]  THRESH_RST = 10'd4;
    localparam logic [7:0]  LIMIT_RST  = 8'd30;
    localparam logic [14:0] PMIN_RST   = 15'd1000;
    localparam logic [14:0] PMAX_RST   = 15'd2000;
    localparam logic [15:0] TTOP_RST   = 16'd39999;

    typedef enum logic [2:0] {
        REG_MOVE_THRESH = 3'd0,
        REG_IDLE_LIMIT  = 3'd1,
        REG_PULSE_MIN   = 3'd2,
        REG_PULSE_MAX   = 3'd3,
        REG_TIMER_TOP   = 3'd4
    } sida_reg_t;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_INIT   = 1'b1
    } sida_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MAP
    } sida_state_t;

    // One axis record as kept in the state memory.
    typedef struct packed {
        logic                attached;
        logic [IDLE_W-1:0]   idle;
        logic [SAMPLE_W-1:0] last;
    } sida_entry_t;

    localparam sida_entry_t ENTRY_RESET = '{attached: 1'b1, idle: '0, last: '0};

    typedef struct packed {
        logic start;
        logic take;
    } sida_map_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [US_W-1:0]   pulse_us;
        logic [TICK_W-1:0] pulse_ticks;
    } sida_map_res_t;

endpackage

@@ hdl/sida_state_ram.sv @@
// Per-axis state memory with synchronous read and reset-valid bits.
module sida_state_ram import sida_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int AW    = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output sida_entry_t   rd_entry,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  sida_entry_t   wr_entry
);

    sida_entry_t mem [DEPTH];
    sida_entry_t rd_data_reg;
    logic        rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written since reset reads as the reset record.
    assign rd_entry = rd_valid_reg ? rd_data_reg : ENTRY_RESET;

endmodule

@@ hdl/sida_pulse_map.sv @@
// Multi-cycle datapath mapping a sample to microseconds and timer ticks.
module sida_pulse_map import sida_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sida_map_ctrl_t      ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [US_W-1:0]     pulse_min,
    input  logic [US_W-1:0]     pulse_max,
    input  logic [TICK_W-1:0]   timer_top,
    output sida_map_res_t       res
);

    logic [4:0]        stage_reg;
    logic              res_valid_reg;
    logic              inv_reg;
    logic [24:0]       prod_reg;
    logic [US_W-1:0]   us_reg;
    logic [30:0]       tus_reg;
    logic [52:0]       xm_reg;
    logic [16:0]       qe_reg;
    logic [26:0]       qm_reg;
    logic [TICK_W-1:0] ticks_reg;

    logic              inv_next;
    logic [US_W-1:0]   span_next;
    logic [15:0]       fold1;
    logic [10:0]       fold2;
    logic [15:0]       quo;
    logic [15:0]       us_wide;
    logic [16:0]       qe_next;
    logic [26:0]       rem;
    logic [16:0]       q_fin;

    always_comb
    begin
        inv_next  = pulse_max < pulse_min;
        span_next = inv_next ? pulse_min - pulse_max : pulse_max - pulse_min;
    end

    // Division by 1023: with p = 1024a + b, p = 1023a + (a + b); folding the
    // residue twice leaves a remainder below twice the divisor.
    always_comb
    begin
        fold1   = 16'(prod_reg[24:10]) + 16'(prod_reg[9:0]);
        fold2   = 11'(fold1[15:10]) + 11'(fold1[9:0]);
        quo     = 16'(prod_reg[24:10]) + 16'(fold1[15:10])
                + ((fold2 >= 11'(SAMPLE_FULL)) ? 16'd1 : 16'd0);
        us_wide = inv_reg ? 16'(pulse_min) - quo : 16'(pulse_min) + quo;
    end

    always_comb
    begin
        qe_next = xm_reg[52:RECIP_SHIFT];
        rem     = 27'(tus_reg[30:PERIOD_SHIFT]) - qm_reg;
        q_fin   = qe_reg + ((rem >= 27'(PERIOD_ODD)) ? 17'd1 : 17'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[3:0], ctrl.start};
            if (stage_reg[4])
            begin
                res_valid_reg <= 1'b1;
            end
            else if (ctrl.take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            inv_reg  <= inv_next;
            prod_reg <= 25'(sample) * 25'(span_next);
        end
        if (stage_reg[0])
        begin
            us_reg <= us_wide[US_W-1:0];
        end
        if (stage_reg[1])
        begin
            tus_reg <= 31'(timer_top) * 31'(us_reg);
        end
        if (stage_reg[2])
        begin
            xm_reg <= 53'(tus_reg[30:PERIOD_SHIFT]) * 53'(RECIP_625);
        end
        if (stage_reg[3])
        begin
            qe_reg <= qe_next;
            qm_reg <= 27'(qe_next) * 27'(PERIOD_ODD);
        end
        if (stage_reg[4])
        begin
            ticks_reg <= (q_fin > 17'(TICK_MAX)) ? TICK_MAX : q_fin[TICK_W-1:0];
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.pulse_us    = us_reg;
    assign res.pulse_ticks = ticks_reg;

endmodule

@@ hdl/servo_idle_detach_axis.sv @@
// Top level: servo axis idle-detach controller with pulse and tick mapping.
//
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the operation
// (update with a sample, or initialise the axis), s_tdata the axis number and
// the 10-bit potentiometer sample. Each accepted beat yields exactly one
// output beat on m_tvalid/m_tready with the mapped pulse width, the timer
// compare value and the drive/detach/reattach flags for that axis.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle; the user must write them only while the block is
// idle, and the block itself does not enforce it. The mapping datapath
// registers span product, pulse width, timer product, reciprocal multiply,
// quotient estimate and its multiple of 625, then corrected, saturated
// ticks; no new beat is taken before the result enters the output register.
// One item is in flight at a time, so reads and write-backs of the state
// memory never overlap.
// Reset clears all axes to sample zero, idle count zero and attached, and
// loads the register defaults; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the block
// takes and processes the next beat meanwhile and waits only once that
// result is ready to leave.
module servo_idle_detach_axis import sida_pkg::*;
#(
    parameter int NUM_AXES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] axis_index, [10:1] pot_reading, rest zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] axis_out, [15:1] pulse_us, [31:16] pulse_ticks,
                                   // [32] drive_valid, [33] detach_event,
                                   // [34] reattach_event, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AXIS_AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    sida_state_t state_reg, state_next;

    logic [9:0]  thresh_reg;
    logic [7:0]  limit_reg;
    logic [14:0] pmin_reg;
    logic [14:0] pmax_reg;
    logic [15:0] ttop_reg;

    logic                op_reg;
    logic                axis_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                drive_reg;
    logic                det_reg;
    logic                reat_reg;

    logic              out_valid_reg;
    logic              out_axis_reg;
    logic [US_W-1:0]   out_us_reg;
    logic [TICK_W-1:0] out_ticks_reg;
    logic              out_drive_reg;
    logic              out_det_reg;
    logic              out_reat_reg;

    logic           accept;
    logic           out_free;
    sida_map_ctrl_t map_ctrl;
    sida_map_res_t  map_res;
    sida_entry_t    rd_entry;
    sida_entry_t    wr_entry;
    logic           wr_en;
    logic           in_range;

    logic [SAMPLE_W-1:0] delta;
    logic                moved;
    logic                drive_next;
    logic                det_next;
    logic                reat_next;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_range = 32'(axis_reg) < NUM_AXES;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            limit_reg  <= LIMIT_RST;
            pmin_reg   <= PMIN_RST;
            pmax_reg   <= PMAX_RST;
            ttop_reg   <= TTOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MOVE_THRESH: thresh_reg <= cfg_data[9:0];
                REG_IDLE_LIMIT:  limit_reg  <= cfg_data[7:0];
                REG_PULSE_MIN:   pmin_reg   <= cfg_data[14:0];
                REG_PULSE_MAX:   pmax_reg   <= cfg_data[14:0];
                REG_TIMER_TOP:   ttop_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (map_res.valid && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        wr_en          = 1'b0;
        map_ctrl.start = 1'b0;
        map_ctrl.take  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                map_ctrl.start = s_tvalid;
            end
            ST_UPDATE: wr_en         = in_range;
            ST_MAP:    map_ctrl.take = map_res.valid && out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Axis state update, applied to the record read during the accept cycle.
    always_comb
    begin
        wr_entry   = rd_entry;
        delta      = (sample_reg > rd_entry.last) ? sample_reg - rd_entry.last
                                                  : rd_entry.last - sample_reg;
        moved      = delta >= thresh_reg;
        det_next   = 1'b0;
        reat_next  = 1'b0;
        wr_entry.last = sample_reg;
        if (op_reg == OP_INIT)
        begin
            wr_entry.attached = 1'b1;
        end
        else
        begin
            if (moved)
            begin
                wr_entry.idle = '0;
                if (!rd_entry.attached)
                begin
                    wr_entry.attached = 1'b1;
                    reat_next         = 1'b1;
                end
            end
            else if (rd_entry.idle != IDLE_SAT)
            begin
                wr_entry.idle = rd_entry.idle + 8'd1;
            end
            // A zero limit makes an attached axis detach on every update.
            if (wr_entry.attached && (wr_entry.idle >= limit_reg))
            begin
                wr_entry.attached = 1'b0;
                det_next          = 1'b1;
            end
        end
        drive_next = wr_entry.attached && in_range;
        det_next   = det_next && in_range;
        reat_next  = reat_next && in_range;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            axis_reg   <= s_tdata[0];
            sample_reg <= s_tdata[10:1];
        end
        if (state_reg == ST_UPDATE)
        begin
            drive_reg <= drive_next;
            det_reg   <= det_next;
            reat_reg  <= reat_next;
        end
        if (map_ctrl.take)
        begin
            out_axis_reg  <= axis_reg;
            out_us_reg    <= map_res.pulse_us;
            out_ticks_reg <= map_res.pulse_ticks;
            out_drive_reg <= drive_reg;
            out_det_reg   <= det_reg;
            out_reat_reg  <= reat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (map_ctrl.take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    sida_state_ram #(
        .DEPTH (NUM_AXES),
        .AW    (AXIS_AW)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (AXIS_AW'(s_tdata[0])),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (AXIS_AW'(axis_reg)),
        .wr_entry (wr_entry)
    );

    sida_pulse_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (map_ctrl),
        .sample    (s_tdata[10:1]),
        .pulse_min (pmin_reg),
        .pulse_max (pmax_reg),
        .timer_top (ttop_reg),
        .res       (map_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reat_reg, out_det_reg, out_drive_reg,
                       out_ticks_reg, out_us_reg, out_axis_reg};

`ifndef SYNTHESIS
    a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted beat did not start a state update");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !map_res.valid)
        else $error("mapping result pending while sequencer idle");

    a_detach_drops_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_det_reg) |-> !out_drive_reg)
        else $error("detached axis still flagged for drive");
`endif

endmodule
